// ===== rtl/assert_macros.svh =====
// Concurrent assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: property does not hold");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequent missing one cycle later");

`define ASSERT_DELAY2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed: consequent missing two cycles later");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`define ASSERT_DELAY2(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rvlsu_pkg.sv =====
package rvlsu_pkg;

    localparam int MEM_BYTES_DEFAULT = 65536;
    localparam int LANES = 4;

    localparam logic [2:0] CMD_LB  = 3'd0;
    localparam logic [2:0] CMD_LBU = 3'd1;
    localparam logic [2:0] CMD_LH  = 3'd2;
    localparam logic [2:0] CMD_LHU = 3'd3;
    localparam logic [2:0] CMD_LW  = 3'd4;
    localparam logic [2:0] CMD_SB  = 3'd5;
    localparam logic [2:0] CMD_SH  = 3'd6;
    localparam logic [2:0] CMD_SW  = 3'd7;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] address;
        logic [31:0] store_data;
    } req_t;

    typedef struct packed {
        logic [31:0] load_data;
        logic        fault;
    } rsp_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] command;
        logic [1:0] offset;
        logic       fault;
    } pending_t;

    function automatic logic is_store(input logic [2:0] command);
        return (command == CMD_SB) || (command == CMD_SH) || (command == CMD_SW);
    endfunction

    function automatic logic [2:0] access_size(input logic [2:0] command);
        logic [2:0] size;
        unique case (command)
            CMD_LB, CMD_LBU, CMD_SB: size = 3'd1;
            CMD_LH, CMD_LHU, CMD_SH: size = 3'd2;
            default:                 size = 3'd4;
        endcase
        return size;
    endfunction

endpackage

// ===== rtl/rvlsu_bank.sv =====
module rvlsu_bank #(
    parameter int DEPTH = rvlsu_pkg::MEM_BYTES_DEFAULT / rvlsu_pkg::LANES,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [IW-1:0] index,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[index] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[index];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rvlsu_decode.sv =====
module rvlsu_decode #(
    parameter int MEM_BYTES = rvlsu_pkg::MEM_BYTES_DEFAULT,
    parameter int IW        = $clog2((MEM_BYTES + 3) / 4)
) (
    input  rvlsu_pkg::req_t                            req,
    input  logic                                       accept,
    output logic [rvlsu_pkg::LANES-1:0][IW-1:0]        lane_index,
    output logic [rvlsu_pkg::LANES-1:0]                lane_we,
    output logic [rvlsu_pkg::LANES-1:0]                lane_re,
    output logic [rvlsu_pkg::LANES-1:0][7:0]           lane_wdata,
    output rvlsu_pkg::pending_t                        info
);

    logic [2:0]  size;
    logic [1:0]  offset;
    logic [29:0] word;
    logic        fault;
    logic        store;
    logic [32:0] last_next;

    assign size      = rvlsu_pkg::access_size(req.command);
    assign offset    = req.address[1:0];
    assign word      = req.address[31:2];
    assign store     = rvlsu_pkg::is_store(req.command);
    assign last_next = {1'b0, req.address} + {30'd0, size};
    assign fault     = last_next > 33'(MEM_BYTES);

    always_comb
    begin
        for (int l = 0; l < rvlsu_pkg::LANES; l++)
        begin
            logic [1:0]  k;
            logic [29:0] word_l;
            logic        used;
            k      = 2'(l) - offset;
            used   = {1'b0, k} < size;
            word_l = word + {29'd0, (2'(l) < offset)};
            lane_index[l] = word_l[IW-1:0];
            lane_wdata[l] = req.store_data[{k, 3'b000} +: 8];
            lane_we[l]    = accept && store && !fault && used;
            lane_re[l]    = accept && !store && !fault && used;
        end
    end

    assign info.valid   = accept;
    assign info.command = req.command;
    assign info.offset  = offset;
    assign info.fault   = fault;

endmodule

// ===== rtl/rvlsu_format.sv =====
module rvlsu_format (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rvlsu_pkg::pending_t                   info,
    input  logic [rvlsu_pkg::LANES-1:0][7:0]      lane_rdata,
    output logic                                  done,
    output rvlsu_pkg::rsp_t                       result
);

    rvlsu_pkg::pending_t stage_reg;
    logic                done_reg;
    rvlsu_pkg::rsp_t     result_reg;
    rvlsu_pkg::rsp_t     result_next;
    logic [31:0]         raw;

    always_comb
    begin
        for (int k = 0; k < rvlsu_pkg::LANES; k++)
        begin
            raw[8*k +: 8] = lane_rdata[2'(k) + stage_reg.offset];
        end
    end

    always_comb
    begin
        unique case (stage_reg.command)
            rvlsu_pkg::CMD_LB:  result_next.load_data = {{24{raw[7]}}, raw[7:0]};
            rvlsu_pkg::CMD_LBU: result_next.load_data = {24'd0, raw[7:0]};
            rvlsu_pkg::CMD_LH:  result_next.load_data = {{16{raw[15]}}, raw[15:0]};
            rvlsu_pkg::CMD_LHU: result_next.load_data = {16'd0, raw[15:0]};
            rvlsu_pkg::CMD_LW:  result_next.load_data = raw;
            rvlsu_pkg::CMD_SB,
            rvlsu_pkg::CMD_SH,
            rvlsu_pkg::CMD_SW:  result_next.load_data = 32'd0;
        endcase
        if (stage_reg.fault)
        begin
            result_next.load_data = 32'd0;
        end
        result_next.fault = stage_reg.fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg.valid <= info.valid;
            done_reg        <= stage_reg.valid;
            if (info.valid)
            begin
                stage_reg.command <= info.command;
                stage_reg.offset  <= info.offset;
                stage_reg.fault   <= info.fault;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_reg.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/rv32_load_store_data_memory.sv =====
// RV32I data memory serving byte, halfword and word loads and stores.
// A request transfers at a rising clock edge where start is high and busy is
// low; request carries the command, the byte address and the store data.
// Busy stays low, so one request can transfer in every cycle.
// The memory is split into four byte lanes, each a synchronous RAM with a
// registered read, so a misaligned access uses each lane at most once.
// A store writes its lanes at the edge where it transfers; a load issued in
// the next cycle already sees the new bytes, so no forwarding is needed.
// The lane RAMs are read at the edge where a load transfers. The next edge
// aligns, extends and registers the result, which is marked by done for a
// single cycle and stays on result until the next result is registered.
// An access running past the memory end sets fault, returns zero and writes
// nothing. Stores return zero load data.
// Reset clears the pipeline stage and the done flag only; memory contents are undefined
// until written. The receiver cannot stall, so every result must be taken.
`include "assert_macros.svh"

module rv32_load_store_data_memory #(
    parameter int MEM_BYTES = rvlsu_pkg::MEM_BYTES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  rvlsu_pkg::req_t request,
    output logic            done,
    output rvlsu_pkg::rsp_t result
);

    localparam int LANE_DEPTH = (MEM_BYTES + rvlsu_pkg::LANES - 1) / rvlsu_pkg::LANES;
    localparam int IW         = $clog2(LANE_DEPTH);

    logic                                  accept;
    logic [rvlsu_pkg::LANES-1:0][IW-1:0]   lane_index;
    logic [rvlsu_pkg::LANES-1:0]           lane_we;
    logic [rvlsu_pkg::LANES-1:0]           lane_re;
    logic [rvlsu_pkg::LANES-1:0][7:0]      lane_wdata;
    logic [rvlsu_pkg::LANES-1:0][7:0]      lane_rdata;
    rvlsu_pkg::pending_t                   info;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rvlsu_decode #(
        .MEM_BYTES (MEM_BYTES),
        .IW        (IW)
    ) u_decode (
        .req        (request),
        .accept     (accept),
        .lane_index (lane_index),
        .lane_we    (lane_we),
        .lane_re    (lane_re),
        .lane_wdata (lane_wdata),
        .info       (info)
    );

    for (genvar l = 0; l < rvlsu_pkg::LANES; l++)
    begin : g_lane
        rvlsu_bank #(
            .DEPTH (LANE_DEPTH),
            .IW    (IW)
        ) u_bank (
            .clk   (clk),
            .we    (lane_we[l]),
            .re    (lane_re[l]),
            .index (lane_index[l]),
            .wdata (lane_wdata[l]),
            .rdata (lane_rdata[l])
        );
    end

    rvlsu_format u_format (
        .clk        (clk),
        .rst_n      (rst_n),
        .info       (info),
        .lane_rdata (lane_rdata),
        .done       (done),
        .result     (result)
    );

    `ASSERT_DELAY2(a_result_follows_transfer, clk, rst_n, accept, done)
    `ASSERT_ALWAYS(a_done_has_transfer, clk, rst_n, !done || $past(accept, 2))
    `ASSERT_ALWAYS(a_fault_no_write, clk, rst_n, !(info.fault && (lane_we != '0)))
    `ASSERT_ALWAYS(a_fault_zero_data, clk, rst_n, !(done && result.fault) || (result.load_data == 32'd0))

endmodule
